/* src/vor_course_deviation_core_defines.svh */
// Assertion macros used by the checker file.
`ifndef VOR_COURSE_DEVIATION_CORE_DEFINES_SVH
`define VOR_COURSE_DEVIATION_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define VCD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("vcd assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define VCD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("vcd assertion failed");

`endif

/* src/vcd_pkg.sv */
package vcd_pkg;

  localparam int ANGLE_BITS = 16;
  localparam int DEV_W      = 16;
  localparam int STEP_W     = 10;
  localparam int TIMER_W    = 16;
  localparam int CFG_W      = 16;
  localparam int CFG_IDX_W  = 1;

  localparam longint unsigned FULL_CIRCLE = 64'd1 << ANGLE_BITS;

  typedef logic [ANGLE_BITS-1:0] angle_t;

  localparam angle_t HALF_CIRCLE    = angle_t'(FULL_CIRCLE >> 1);
  localparam angle_t QUARTER_CIRCLE = angle_t'(FULL_CIRCLE >> 2);
  // largest magnitude with mag * 360 <= 85 * full circle
  localparam angle_t MAG85_LIMIT    = angle_t'((64'd85 * FULL_CIRCLE) / 64'd360);

  // ten degrees full scale in Q1.14: mag * 36 * 2^14 / full circle
  localparam int     SCALE_W   = 20;
  localparam longint unsigned DEV_SCALE = 64'd36 * 64'd16384;
  localparam int     PROD_W    = ANGLE_BITS + SCALE_W;
  localparam logic [DEV_W-1:0] Q14_ONE = DEV_W'(16384);

  localparam logic [TIMER_W-1:0] HOLD_TIME_RESET = TIMER_W'(3000);

  localparam logic [CFG_IDX_W-1:0] CFG_OBS_COURSE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TIME  = 1'b1;

  typedef struct packed {
    logic   bvalid;
    angle_t held;
  } track_t;

  typedef struct packed {
    logic signed [DEV_W-1:0] deviation;
    logic                    to_flag;
    logic                    from_flag;
    logic                    bearing_ok;
    angle_t                  bearing;
  } result_t;

endpackage

/* src/vor_course_deviation_core.sv */
// VOR course deviation indicator core.
// Pipeline: state update register, then result register, between input beat
// and result beat. Throughput: one beat per cycle while out_ready is high.
// Reset (synchronous, active low): bearing, loss timer and both pipeline
// valids cleared; obs_course resets to 0, hold_time_ms to 3000.
module vor_course_deviation_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [vcd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [vcd_pkg::CFG_W-1:0]      cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_func,
  input  logic                           in_meas_valid,
  input  vcd_pkg::angle_t                in_meas_radial,
  input  logic [vcd_pkg::STEP_W-1:0]     in_step_ms,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [vcd_pkg::DEV_W-1:0] out_deviation,
  output logic                           out_to_flag,
  output logic                           out_from_flag,
  output logic                           out_bearing_ok,
  output vcd_pkg::angle_t                out_bearing_out
);
  import vcd_pkg::*;

  angle_t             obs_course_r;
  logic [TIMER_W-1:0] hold_time_r;
  logic               s1_valid_r, s1_valid_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               out_free;
  logic               s1_adv;
  logic               in_fire;
  track_t             trk;
  result_t            res;
  result_t            res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      obs_course_r <= '0;
      hold_time_r  <= HOLD_TIME_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_OBS_COURSE: obs_course_r <= cfg_wdata[ANGLE_BITS-1:0];
        CFG_HOLD_TIME:  hold_time_r  <= cfg_wdata[TIMER_W-1:0];
        default: ;
      endcase
    end
  end

  assign out_free = !out_valid_r || out_ready;
  assign s1_adv   = s1_valid_r && out_free;
  assign in_ready = !s1_valid_r || out_free;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire)     s1_valid_nxt = 1'b1;
    else if (s1_adv) s1_valid_nxt = 1'b0;
    out_valid_nxt = out_valid_r;
    if (s1_adv)         out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  vcd_track u_track (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_fire      (in_fire),
    .func         (in_func),
    .meas_valid   (in_meas_valid),
    .meas_radial  (in_meas_radial),
    .step_ms      (in_step_ms),
    .hold_time_ms (hold_time_r),
    .trk          (trk)
  );

  vcd_deviation u_dev (
    .trk        (trk),
    .obs_course (obs_course_r),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (s1_adv) res_r <= res;
  end

  assign out_valid       = out_valid_r;
  assign out_deviation   = res_r.deviation;
  assign out_to_flag     = res_r.to_flag;
  assign out_from_flag   = res_r.from_flag;
  assign out_bearing_ok  = res_r.bearing_ok;
  assign out_bearing_out = res_r.bearing;

endmodule

/* src/vcd_track.sv */
module vcd_track (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_fire,
  input  logic                         func,
  input  logic                         meas_valid,
  input  vcd_pkg::angle_t              meas_radial,
  input  logic [vcd_pkg::STEP_W-1:0]   step_ms,
  input  logic [vcd_pkg::TIMER_W-1:0]  hold_time_ms,
  output vcd_pkg::track_t              trk
);
  import vcd_pkg::*;

  angle_t               held_r, held_nxt;
  logic                 bvalid_r, bvalid_nxt;
  logic                 running_r, running_nxt;
  logic [TIMER_W-1:0]   elapsed_r, elapsed_nxt;
  logic [TIMER_W:0]     elapsed_sum;
  track_t               trk_r;

  assign elapsed_sum = {1'b0, elapsed_r} + (TIMER_W+1)'(step_ms);

  always_comb begin
    held_nxt    = held_r;
    bvalid_nxt  = bvalid_r;
    running_nxt = running_r;
    elapsed_nxt = elapsed_r;
    if (func) begin
      // power switch: bearing dropped, loss timer left alone
      held_nxt   = '0;
      bvalid_nxt = 1'b0;
    end else if (!meas_valid) begin
      if (!running_r) begin
        running_nxt = 1'b1;
        elapsed_nxt = '0;
      end else begin
        elapsed_nxt = elapsed_sum[TIMER_W] ? '1 : elapsed_sum[TIMER_W-1:0];
        if (elapsed_nxt > hold_time_ms) bvalid_nxt = 1'b0;
      end
    end else begin
      running_nxt = 1'b0;
      elapsed_nxt = '0;
      bvalid_nxt  = 1'b1;
      held_nxt    = meas_radial - HALF_CIRCLE;
    end
    if (!bvalid_nxt) held_nxt = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r    <= '0;
      bvalid_r  <= 1'b0;
      running_r <= 1'b0;
      elapsed_r <= '0;
    end else if (in_fire) begin
      held_r    <= held_nxt;
      bvalid_r  <= bvalid_nxt;
      running_r <= running_nxt;
      elapsed_r <= elapsed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      trk_r.bvalid <= bvalid_nxt;
      trk_r.held   <= held_nxt;
    end
  end

  assign trk = trk_r;

endmodule

/* src/vcd_deviation.sv */
module vcd_deviation (
  input  vcd_pkg::track_t  trk,
  input  vcd_pkg::angle_t  obs_course,
  output vcd_pkg::result_t res
);
  import vcd_pkg::*;

  angle_t                u;
  angle_t                mag0;
  angle_t                mag;
  logic                  neg;
  logic                  to_f;
  logic                  from_f;
  logic [PROD_W-1:0]     prod;
  logic [SCALE_W-1:0]    q;
  logic [DEV_W-1:0]      q_c;

  always_comb begin
    // radial minus course; held bearing is radial minus half a circle
    u    = trk.held + HALF_CIRCLE - obs_course;
    neg  = (u > HALF_CIRCLE);
    mag0 = neg ? (angle_t'(0) - u) : u;
    to_f   = 1'b0;
    from_f = 1'b0;
    if (mag0 > QUARTER_CIRCLE) begin
      mag = HALF_CIRCLE - mag0;
      if (mag == '0) neg = 1'b0;
      to_f = (mag <= MAG85_LIMIT);
    end else begin
      mag    = mag0;
      from_f = (mag <= MAG85_LIMIT);
    end
    prod = PROD_W'(mag) * PROD_W'(DEV_SCALE) + PROD_W'(FULL_CIRCLE >> 1);
    q    = prod[PROD_W-1:ANGLE_BITS];
    q_c  = (q > SCALE_W'(Q14_ONE)) ? Q14_ONE : q[DEV_W-1:0];

    if (trk.bvalid) begin
      res.deviation  = neg ? $signed(DEV_W'(0) - q_c) : $signed(q_c);
      res.to_flag    = to_f;
      res.from_flag  = from_f;
      res.bearing_ok = 1'b1;
      res.bearing    = trk.held;
    end else begin
      res = '0;
    end
  end

endmodule

/* src/vcd_checker.sv */
`include "vor_course_deviation_core_defines.svh"

module vcd_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic signed [vcd_pkg::DEV_W-1:0] out_deviation,
  input logic                           out_to_flag,
  input logic                           out_from_flag,
  input logic                           out_bearing_ok,
  input vcd_pkg::angle_t                out_bearing_out
);

  // a stalled result beat holds its deviation and bearing
  `VCD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_deviation) && $stable(out_bearing_out))

  // no bearing means an all-zero result
  `VCD_ASSERT_NOW(a_invalid_zero, clk, rst_n, out_valid && !out_bearing_ok, out_deviation == 0 && !out_to_flag && !out_from_flag && out_bearing_out == 0)

  // TO and FROM never shown together
  `VCD_ASSERT_NOW(a_to_from_excl, clk, rst_n, out_valid, !(out_to_flag && out_from_flag))

  // deviation clamped to full scale
  `VCD_ASSERT_NOW(a_dev_clamp, clk, rst_n, out_valid, out_deviation <= 16'sd16384 && out_deviation >= -16'sd16384)

endmodule

bind vor_course_deviation_core vcd_checker u_vcd_checker (.*);
